// ----- hdl/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and codes for the key/value table
// Request kinds, status codes, back-end states and the front/back queue word.
// ----------------------------------------------------------------------------
`default_nettype none
package kvt_pkg;

  localparam logic [2:0] FUNC_ADD    = 3'd0;
  localparam logic [2:0] FUNC_GET    = 3'd1;
  localparam logic [2:0] FUNC_EDIT   = 3'd2;
  localparam logic [2:0] FUNC_DELETE = 3'd3;
  localparam logic [2:0] FUNC_FIND   = 3'd4;
  localparam logic [2:0] FUNC_ENUM   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NO_ROOM   = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CMP,
    S_FREE_RD,
    S_FREE_CMP,
    S_ADD_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_ENUM_RD,
    S_ENUM_OUT,
    S_RESULT
  } back_state_t;

  // request word handed from the front end to the back end
  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] key;
    logic [31:0] value;
    logic [6:0]  room;
  } req_t;

  // result word from the back end
  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] key;
    logic [31:0] value;
    logic [6:0]  total;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/kvt_front.sv -----
// ----------------------------------------------------------------------------
// kvt_front: request intake
// Accepts request beats and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module kvt_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire kvt_pkg::req_t  in_req,
  output logic                q_valid,
  input  wire                 q_ready,
  output kvt_pkg::req_t       q_req
);

  kvt_pkg::req_t queue [kvt_pkg::QUEUE_DEPTH];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;
  logic          pop;

  assign in_ready = (fill != 2'(kvt_pkg::QUEUE_DEPTH));
  assign q_valid  = (fill != 2'd0);
  assign q_req    = queue[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // hold payloads
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_req;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ----- hdl/kvt_back.sv -----
// ----------------------------------------------------------------------------
// kvt_back: list engine
// Walks the linked list in memory and carries out one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module kvt_back #(
  parameter int CAPACITY    = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  output logic                q_ready,
  input  wire kvt_pkg::req_t  q_req,
  output logic                res_valid,
  input  wire                 res_ready,
  output kvt_pkg::res_t       res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  // memories
  logic [KEY_WIDTH-1:0]   key_mem   [CAPACITY];
  logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
  logic [LW-1:0]          next_mem  [CAPACITY];
  logic [LW-1:0]          prev_mem  [CAPACITY];
  logic [CAPACITY-1:0]    used;

  logic [LW-1:0] head;
  logic [LW-1:0] count;

  kvt_pkg::back_state_t state, state_next;
  kvt_pkg::req_t        req;
  logic [LW-1:0]        cur;
  logic [LW-1:0]        steps;
  logic [LW-1:0]        slot;
  logic [AW-1:0]        free_idx;

  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic [LW-1:0]          rd_next;
  logic [LW-1:0]          rd_prev;
  logic                   rd_used;

  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_val;
  logic                   hit;
  logic                   walk_end;
  kvt_pkg::res_t          res_next;
  logic                   load_res;

  assign req_key  = KEY_WIDTH'(req.key);
  assign req_val  = VALUE_WIDTH'(req.value);
  assign hit      = rd_used && (rd_key == req_key);
  assign walk_end = (rd_next >= NIL) || (steps + 1'b1 >= LW'(CAPACITY));
  assign q_ready  = (state == kvt_pkg::S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kvt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and result build
  always_comb begin
    state_next = state;
    load_res   = 1'b0;
    res_next   = '0;
    res_next.total = 7'(count);
    res_next.last  = 1'b1;
    case (state)
      kvt_pkg::S_IDLE: begin
        if (q_valid) begin
          case (q_req.func)
            kvt_pkg::FUNC_ADD, kvt_pkg::FUNC_GET, kvt_pkg::FUNC_EDIT,
            kvt_pkg::FUNC_DELETE, kvt_pkg::FUNC_FIND: begin
              state_next = (head >= NIL) ? kvt_pkg::S_WALK_CMP : kvt_pkg::S_WALK_RD;
            end
            kvt_pkg::FUNC_ENUM: begin
              state_next = (head >= NIL || q_req.room < 7'(count)) ?
                           kvt_pkg::S_WALK_CMP : kvt_pkg::S_ENUM_RD;
            end
            default: begin
              state_next = kvt_pkg::S_WALK_CMP;
            end
          endcase
        end
      end
      kvt_pkg::S_WALK_RD: begin
        state_next = kvt_pkg::S_WALK_CMP;
      end
      kvt_pkg::S_WALK_CMP: begin
        // a miss with more links to follow keeps walking
        if (cur < NIL && !hit && !walk_end && req.func <= kvt_pkg::FUNC_FIND) begin
          state_next = kvt_pkg::S_WALK_RD;
        end else begin
          load_res   = 1'b1;
          state_next = kvt_pkg::S_RESULT;
          case (req.func)
            kvt_pkg::FUNC_ADD: begin
              if (cur < NIL && hit) begin
                res_next.status = kvt_pkg::ST_DUPLICATE;
              end else if (count >= LW'(CAPACITY)) begin
                res_next.status = kvt_pkg::ST_FULL;
              end else begin
                load_res   = 1'b0;
                state_next = kvt_pkg::S_FREE_RD;
              end
            end
            kvt_pkg::FUNC_GET: begin
              if (cur < NIL && hit) begin
                res_next.value = 32'(rd_value);
              end else begin
                res_next.status = kvt_pkg::ST_NOT_FOUND;
              end
            end
            kvt_pkg::FUNC_EDIT: begin
              if (!(cur < NIL && hit)) begin
                res_next.status = kvt_pkg::ST_NOT_FOUND;
              end
            end
            kvt_pkg::FUNC_DELETE: begin
              if (cur < NIL && hit) begin
                load_res   = 1'b0;
                state_next = kvt_pkg::S_DEL_RD;
              end else begin
                res_next.status = kvt_pkg::ST_NOT_FOUND;
              end
            end
            kvt_pkg::FUNC_FIND: begin
              res_next.found = (cur < NIL) && hit;
            end
            kvt_pkg::FUNC_ENUM: begin
              if (req.room < 7'(count)) begin
                res_next.status = kvt_pkg::ST_NO_ROOM;
              end
            end
            default: begin
            end
          endcase
        end
      end
      kvt_pkg::S_FREE_RD: begin
        if (!used[free_idx]) begin
          state_next = kvt_pkg::S_ADD_WR;
        end
      end
      kvt_pkg::S_ADD_WR: begin
        load_res   = 1'b1;
        state_next = kvt_pkg::S_RESULT;
        res_next.total = 7'(count + 1'b1);
      end
      kvt_pkg::S_DEL_RD: begin
        state_next = kvt_pkg::S_DEL_WR;
      end
      kvt_pkg::S_DEL_WR: begin
        load_res   = 1'b1;
        state_next = kvt_pkg::S_RESULT;
        res_next.value = 32'(rd_value);
        res_next.total = 7'(count - 1'b1);
      end
      kvt_pkg::S_ENUM_RD: begin
        state_next = kvt_pkg::S_ENUM_OUT;
      end
      kvt_pkg::S_ENUM_OUT: begin
        load_res   = 1'b1;
        res_next.key  = 32'(rd_key);
        res_next.last = walk_end;
        state_next = kvt_pkg::S_RESULT;
      end
      kvt_pkg::S_RESULT: begin
        if (res_ready) begin
          state_next = (req.func == kvt_pkg::FUNC_ENUM && !res.last) ?
                       kvt_pkg::S_ENUM_RD : kvt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kvt_pkg::S_IDLE;
      end
    endcase
  end

  assign res_valid = (state == kvt_pkg::S_RESULT);

  // memory reads, registered
  always_ff @(posedge clk) begin
    if (cur < NIL) begin
      rd_key   <= key_mem[cur[AW-1:0]];
      rd_value <= value_mem[cur[AW-1:0]];
      rd_next  <= next_mem[cur[AW-1:0]];
      rd_prev  <= prev_mem[cur[AW-1:0]];
    end
    rd_used <= (cur < NIL) ? used[cur[AW-1:0]] : 1'b0;
  end

  // request, walk pointer and result registers
  always_ff @(posedge clk) begin
    if (load_res) begin
      res <= res_next;
    end
    case (state)
      kvt_pkg::S_IDLE: begin
        req   <= q_req;
        cur   <= head;
        steps <= '0;
        free_idx <= '0;
      end
      kvt_pkg::S_WALK_CMP: begin
        slot <= cur;
        if (!hit && !walk_end) begin
          cur   <= rd_next;
          steps <= steps + 1'b1;
        end
      end
      kvt_pkg::S_FREE_RD: begin
        if (used[free_idx]) free_idx <= free_idx + 1'b1;
      end
      kvt_pkg::S_ENUM_OUT: begin
        cur   <= rd_next;
        steps <= steps + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (state == kvt_pkg::S_ADD_WR) begin
      key_mem[free_idx]   <= req_key;
      value_mem[free_idx] <= req_val;
      next_mem[free_idx]  <= head;
    end
    if (state == kvt_pkg::S_WALK_CMP && req.func == kvt_pkg::FUNC_EDIT
        && cur < NIL && hit) begin
      value_mem[cur[AW-1:0]] <= req_val;
    end
    if (state == kvt_pkg::S_DEL_WR && slot != head && rd_prev < NIL) begin
      next_mem[rd_prev[AW-1:0]] <= rd_next;
    end
  end

  // prev links share one write port: old head on the free-slot hit, new slot on the add, successor on the delete
  always_ff @(posedge clk) begin
    if (state == kvt_pkg::S_FREE_RD && !used[free_idx] && head < NIL) begin
      prev_mem[head[AW-1:0]] <= LW'(free_idx);
    end
    if (state == kvt_pkg::S_ADD_WR) begin
      prev_mem[free_idx] <= NIL;
    end
    if (state == kvt_pkg::S_DEL_WR && rd_next < NIL) begin
      prev_mem[rd_next[AW-1:0]] <= rd_prev;
    end
  end

  // head, count and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= NIL;
      count <= '0;
      used  <= '0;
    end else if (state == kvt_pkg::S_ADD_WR) begin
      head  <= LW'(free_idx);
      count <= count + 1'b1;
      used[free_idx] <= 1'b1;
    end else if (state == kvt_pkg::S_DEL_WR) begin
      if (slot == head) head <= rd_next;
      count <= count - 1'b1;
      used[slot[AW-1:0]] <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/key_value_table.sv -----
// ----------------------------------------------------------------------------
// key_value_table: bounded key/value list
// Doubly linked list in memory, newest first; add, get, edit, delete, find,
// enumerate.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  s_axis   in   tdata: func, req_key, req_value, room
//  m_axis   out  tdata: status, found, key_out, value_out, entry_total; tlast: last
//
//  A lookup visits each list entry in a read state and then a compare state. Delete
//  adds a read and a write of the found entry; add scans the slots from the lowest
//  index for a free one, then writes it. Enumerate reads, outputs and then holds
//  each beat, one entry at a time. Reset clears the slot flags, head and count at
//  once. A stalled m_axis holds the engine; two requests queue while it works.
// ----------------------------------------------------------------------------
`default_nettype none
module key_value_table #(
  parameter int CAPACITY    = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [79:0]  s_axis_tdata,  // func[2:0], req_key, req_value, room[6:0]
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [79:0]  m_axis_tdata,  // status, found, key_out, value_out, entry_total
  output logic         m_axis_tlast
);

  kvt_pkg::req_t in_req;
  kvt_pkg::req_t q_req;
  kvt_pkg::res_t res;
  logic          q_valid;
  logic          q_ready;

  assign in_req.func  = s_axis_tdata[2:0];
  assign in_req.key   = s_axis_tdata[34:3];
  assign in_req.value = s_axis_tdata[66:35];
  assign in_req.room  = s_axis_tdata[73:67];

  kvt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_req    (q_req)
  );

  kvt_back #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {5'd0, res.total, res.value, res.key, res.found, res.status};
  assign m_axis_tlast = res.last;

  // a queued request is taken only while no beat waits
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !q_ready) else $error("request taken during output");

  // a result never reports more entries than capacity
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.total <= 7'(CAPACITY))) else $error("entry total out of range");

  // an error beat with a zero key is always the final beat
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.key == 32'd0 && res.status != kvt_pkg::ST_OK) |-> m_axis_tlast)
    else $error("error beat without last");

endmodule
`default_nettype wire
